[rtl/q128_pkg.sv]
// ----------------------------------------------------------------------------
// q128_pkg
// Shared types and constants for the binary128 add/subtract pipeline.
// ----------------------------------------------------------------------------
`default_nettype none
package q128_pkg;
    localparam int unsigned ExpW  = 15;
    localparam int unsigned FracW = 112;
    localparam int unsigned MantW = 116;   // hidden bit, fraction, guard, round, sticky
    localparam logic [ExpW-1:0] ExpMax = 15'h7FFF;

    // Information that stage one hands to stage two.
    typedef struct packed {
        logic           special;
        logic [127:0]   special_res;
        logic           zero_res;
        logic           invalid;
        logic           sign;
        logic           eff_sub;
        logic [ExpW-1:0] ex;
        logic [MantW-1:0] mx;
        logic [MantW-1:0] my;
    } s1_t;

    // Information that stage two hands to stage three.
    typedef struct packed {
        logic           special;
        logic [127:0]   special_res;
        logic           zero_res;
        logic           invalid;
        logic           sign;
        logic [ExpW:0]  ex;
        logic [MantW:0] sum;
    } s2_t;

    // Shift right with a sticky bit kept in the lowest position.
    function automatic logic [MantW-1:0] shr_sticky(input logic [MantW-1:0] v,
                                                    input logic [ExpW-1:0] n);
        logic [MantW-1:0] r;
        logic [MantW-1:0] mask;
        begin
            if (n >= ExpW'(MantW)) begin
                r = {{(MantW-1){1'b0}}, |v};
            end else begin
                mask = ~({MantW{1'b1}} << n[6:0]);
                r = v >> n[6:0];
                r[0] = r[0] | (|(v & mask));
            end
            return r;
        end
    endfunction
endpackage
`default_nettype wire

[rtl/binary128_add_sub_core.sv]
// ----------------------------------------------------------------------------
// binary128_add_sub_core
// Pipelined IEEE 754 binary128 adder/subtractor, round to nearest even.
// ----------------------------------------------------------------------------
// Channel | Ports                                   | Direction
// s_      | a_high a_low b_high b_low operation     | in  (valid/ready)
// m_      | sum_high sum_low invalid                | out (valid/ready)
//
// An accepted word passes the three registered align / add / normalize stages
// in turn and is then offered as a result. One word per cycle can enter while
// the output is free; the rate is set by that pipeline. A stalled output holds
// the result stage and each full stage behind it up to the first empty one; a
// bubble in any stage is filled. Reset clears the stage valid bits only.
// ----------------------------------------------------------------------------
`default_nettype none
module binary128_add_sub_core (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [63:0] s_a_high,
    input  wire logic [63:0] s_a_low,
    input  wire logic [63:0] s_b_high,
    input  wire logic [63:0] s_b_low,
    input  wire logic        s_operation,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [63:0]      m_sum_high,
    output logic [63:0]      m_sum_low,
    output logic             m_invalid
);
    import q128_pkg::*;

    s1_t s1_next, s1_reg;
    s2_t s2_next, s2_reg;
    logic [127:0] res_next, res_reg;
    logic inv_next, inv_reg;
    logic v1_reg, v2_reg, v3_reg;
    logic en3, en2, en1;

    q128_align u_align (.a_high(s_a_high), .a_low(s_a_low), .b_high(s_b_high),
                        .b_low(s_b_low), .operation(s_operation), .st(s1_next));
    q128_addsub u_addsub (.st_in(s1_reg), .st_out(s2_next));
    q128_norm u_norm (.st(s2_reg), .res(res_next), .inv(inv_next));

    // Each stage advances when the next one is empty or moving.
    assign en3 = !v3_reg || m_ready;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;
    assign s_ready = en1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (en1) v1_reg <= s_valid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (en1) s1_reg <= s1_next;
        if (en2) s2_reg <= s2_next;
        if (en3) begin
            res_reg <= res_next;
            inv_reg <= inv_next;
        end
    end

    assign m_valid    = v3_reg;
    assign m_sum_high = res_reg[127:64];
    assign m_sum_low  = res_reg[63:0];
    assign m_invalid  = inv_reg;
endmodule
`default_nettype wire

[rtl/q128_align.sv]
// ----------------------------------------------------------------------------
// q128_align
// Stage one: special cases, operand ordering and mantissa alignment.
// ----------------------------------------------------------------------------
`default_nettype none
module q128_align (
    input  wire logic [63:0] a_high,
    input  wire logic [63:0] a_low,
    input  wire logic [63:0] b_high,
    input  wire logic [63:0] b_low,
    input  wire logic        operation,
    output q128_pkg::s1_t    st
);
    import q128_pkg::*;

    logic [127:0] x0, y0, x1, y1, xo, yo;
    logic [14:0] ex1, exo, eyo, exn, eyn, d;
    logic x1_nan, y1_nan, x_snan, y_snan, y_inf_opp;
    logic [MantW-1:0] mx, my;

    always_comb begin
        x0 = {a_high, a_low};
        y0 = {b_high ^ {operation, 63'd0}, b_low};
        // Rank for NaN selection uses bits 126..96.
        if (y0[126:96] > x0[126:96]) begin
            x1 = y0; y1 = x0;
        end else begin
            x1 = x0; y1 = y0;
        end
        ex1    = x1[126:112];
        x1_nan = (ex1 == ExpMax) && (x1[111:0] != '0);
        y1_nan = (y1[126:112] == ExpMax) && (y1[111:0] != '0);
        x_snan = x1_nan && !x1[111];
        y_snan = y1_nan && !y1[111];
        y_inf_opp = (y1[126:112] == ExpMax) && (x1[127] != y1[127]);

        st = '0;
        st.invalid = x_snan || y_snan;
        if (ex1 == ExpMax) begin
            st.special = 1'b1;
            if (x1_nan) begin
                st.special_res = x1 | {16'd0, 1'b1, 111'd0};
            end else if (y1_nan) begin
                st.special_res = y1 | {16'd0, 1'b1, 111'd0};
            end else if (y_inf_opp) begin
                st.special_res = {64'h7FFF800000000000, 64'd0};
                st.invalid = 1'b1;
            end else begin
                st.special_res = x1;
            end
        end

        // Order by magnitude.
        if (y1[126:0] > x1[126:0]) begin
            xo = y1; yo = x1;
        end else begin
            xo = x1; yo = y1;
        end
        st.zero_res = (xo[126:0] == yo[126:0]) && (xo[127] != yo[127]);
        st.sign    = xo[127];
        st.eff_sub = xo[127] ^ yo[127];
        exo = xo[126:112];
        eyo = yo[126:112];
        exn = (exo != '0) ? exo : 15'd1;
        eyn = (eyo != '0) ? eyo : 15'd1;
        mx  = {(exo != '0), xo[111:0], 3'b000};
        my  = {(eyo != '0), yo[111:0], 3'b000};
        d   = exn - eyn;
        st.ex = exn;
        st.mx = mx;
        st.my = shr_sticky(my, d);
    end
endmodule
`default_nettype wire

[rtl/q128_addsub.sv]
// ----------------------------------------------------------------------------
// q128_addsub
// Stage two: mantissa add or subtract with carry handling.
// ----------------------------------------------------------------------------
`default_nettype none
module q128_addsub (
    input  q128_pkg::s1_t st_in,
    output q128_pkg::s2_t st_out
);
    import q128_pkg::*;

    logic [MantW:0] s;

    always_comb begin
        if (st_in.eff_sub) begin
            s = {1'b0, st_in.mx} - {1'b0, st_in.my};
        end else begin
            s = {1'b0, st_in.mx} + {1'b0, st_in.my};
        end
        st_out.special     = st_in.special;
        st_out.special_res = st_in.special_res;
        st_out.zero_res    = st_in.zero_res;
        st_out.invalid     = st_in.invalid;
        st_out.sign        = st_in.sign;
        st_out.ex          = {1'b0, st_in.ex};
        st_out.sum         = s;
        // A carry out shifts right once, folding the dropped bit into sticky.
        if (s[MantW]) begin
            st_out.sum = {1'b0, s[MantW:2], s[1] | s[0]};
            st_out.ex  = {1'b0, st_in.ex} + 16'd1;
        end
    end
endmodule
`default_nettype wire

[rtl/q128_norm.sv]
// ----------------------------------------------------------------------------
// q128_norm
// Stage three: leading-zero normalization, rounding and packing.
// ----------------------------------------------------------------------------
`default_nettype none
module q128_norm (
    input  q128_pkg::s2_t st,
    output logic [127:0]  res,
    output logic          inv
);
    import q128_pkg::*;

    logic [MantW-1:0] m;
    logic [6:0]  lz;
    logic        found;
    logic [15:0] sh, ex, exr;
    logic [113:0] r;
    logic [2:0]  g;

    always_comb begin
        m = st.sum[MantW-1:0];
        // Leading-zero count over the 116-bit mantissa.
        lz = 7'd0;
        found = 1'b0;
        for (int i = MantW - 1; i >= 0; i--) begin
            if (!found && m[i]) begin
                found = 1'b1;
                lz = 7'(MantW - 1 - i);
            end
        end
        sh = (16'(lz) < st.ex - 16'd1) ? 16'(lz) : st.ex - 16'd1;
        m  = m << sh[6:0];
        ex = st.ex - sh;
        // Round to nearest even; bit 113 catches a carry out of the mantissa.
        g  = m[2:0];
        r  = {1'b0, m[MantW-1:3]};
        if (g > 3'd4 || (g == 3'd4 && r[0])) begin
            r = r + 114'd1;
        end
        exr = ex;
        if (r[113]) begin
            r = r >> 1;
            exr = ex + 16'd1;
        end
        inv = st.invalid;
        if (st.special) begin
            res = st.special_res;
        end else if (st.zero_res) begin
            res = '0;
            inv = 1'b0;
        end else if (exr >= {1'b0, ExpMax}) begin
            res = {st.sign, ExpMax, 112'd0};
        end else begin
            // Without the hidden bit the result is subnormal.
            res = {st.sign, (r[112] ? exr[14:0] : 15'd0), r[111:0]};
        end
    end
endmodule
`default_nettype wire

[rtl/q128_checker.sv]
// ----------------------------------------------------------------------------
// q128_checker
// Port-level checks of the binary128 add/subtract core.
// ----------------------------------------------------------------------------
`default_nettype none
module q128_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_valid,
    input wire logic        s_ready,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [63:0] m_sum_high
);
    // A held result word stays put.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_sum_high))
        else $error("result changed while stalled");
    // The core is ready whenever the output is free.
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        m_ready |-> s_ready)
        else $error("input blocked with output free");
    // An accepted word is offered at the output once it has moved through the add
    // and normalize stages with the output free.
    a_lat: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready ##1 m_ready ##1 m_ready |=> m_valid)
        else $error("word lost in pipeline");
    // Nothing comes out right after reset.
    a_rst: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("valid after reset");
endmodule

bind binary128_add_sub_core q128_checker u_q128_checker (
    .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
    .m_valid(m_valid), .m_ready(m_ready), .m_sum_high(m_sum_high));
`default_nettype wire
